// ===== rtl/core/fssd_pkg.sv =====
// Shared types and constants for the debounced fan speed selector.
package fssd_pkg;

   // Speed levels that the selector cycles through (0 .. NUM_LEVELS-1).
   localparam int unsigned NUM_LEVELS = 4;

   localparam int unsigned LEVEL_W    = 2;
   localparam int unsigned PWM_W      = 8;
   localparam int unsigned DEBOUNCE_W = 16;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_PWM_TOP        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DUTY_LOW       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DUTY_MID       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DUTY_FULL      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_TICKS = 3'd4;

   // Register reset values.
   localparam logic [PWM_W-1:0]      PWM_TOP_RST        = 8'd10;
   localparam logic [PWM_W-1:0]      DUTY_LOW_RST       = 8'd4;
   localparam logic [PWM_W-1:0]      DUTY_MID_RST       = 8'd7;
   localparam logic [PWM_W-1:0]      DUTY_FULL_RST      = 8'd10;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TICKS_RST = 16'd6000;

   // Speed level codes.
   localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 2'd3;

   // Action waiting for the debounce count to expire.
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SPEED  = 2'd1,
      ACT_ENABLE = 2'd2
   } action_type;

endpackage

// ===== rtl/core/fan_speed_selector_debounced_pwm.sv =====
// Debounced two-button fan speed selector with PWM drive and speed LEDs.
//
// Usage:
//   Every req_ beat is one timer tick carrying the two button-press events
//   (speed, enable). Every tick produces exactly one rsp_ beat: the PWM drive
//   level for that tick, three speed LEDs, the enabled flag and the level.
//   Both channels use valid/ready; a beat moves when valid and ready are high.
//
// Timing:
//   A tick is captured into an input register, then the whole tick update
//   (press capture, debounce count, action apply, duty select, PWM compare
//   and count advance) is combinational logic feeding the result register.
//   A tick passes through the input register and then the result register
//   before its rsp_ beat can move; throughput is one tick per cycle while
//   rsp_ready stays high.
//
// Reset and stalls:
//   reset (synchronous, active high) loads the default registers, clears the
//   level, the enable flag, the debounce state and the PWM counter (PWM idle
//   until the first applied action), and empties both stages. When rsp_ready
//   is low the result holds; one more tick waits in the input register, and
//   req_ready drops only once both are full.
//   Write the csr_ registers only while no tick is in flight.
module fan_speed_selector_debounced_pwm
   import fssd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_speed_press,
   input  logic                  req_enable_press,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_pwm_out,
   output logic                  rsp_led_low,
   output logic                  rsp_led_mid,
   output logic                  rsp_led_full,
   output logic                  rsp_fan_on,
   output logic [LEVEL_W-1:0]    rsp_level_now,

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [PWM_W-1:0]      pwm_top_ff;
   logic [PWM_W-1:0]      duty_low_ff;
   logic [PWM_W-1:0]      duty_mid_ff;
   logic [PWM_W-1:0]      duty_full_ff;
   logic [DEBOUNCE_W-1:0] debounce_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_top_ff        <= PWM_TOP_RST;
         duty_low_ff       <= DUTY_LOW_RST;
         duty_mid_ff       <= DUTY_MID_RST;
         duty_full_ff      <= DUTY_FULL_RST;
         debounce_ticks_ff <= DEBOUNCE_TICKS_RST;
      end else if (csr_we) begin
         // Indexes beyond the register list fall through and are dropped.
         unique case (csr_addr)
            CSR_PWM_TOP:        pwm_top_ff        <= csr_wdata[PWM_W-1:0];
            CSR_DUTY_LOW:       duty_low_ff       <= csr_wdata[PWM_W-1:0];
            CSR_DUTY_MID:       duty_mid_ff       <= csr_wdata[PWM_W-1:0];
            CSR_DUTY_FULL:      duty_full_ff      <= csr_wdata[PWM_W-1:0];
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: input register feeding the result register
   // ---------------------------------------------------------------
   logic in_valid_ff;
   logic in_speed_ff;
   logic in_enable_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic advance;

   // Result slot can take a new beat when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_speed_ff  <= req_speed_press;
         in_enable_ff <= req_enable_press;
      end
   end

   // ---------------------------------------------------------------
   // Tick state
   // ---------------------------------------------------------------
   logic [LEVEL_W-1:0]    level_ff,    level_in;
   logic                  enabled_ff,  enabled_in;
   action_type            pending_ff,  pending_in;
   logic [DEBOUNCE_W-1:0] count_ff,    count_in;
   logic                  active_ff,   active_in;
   logic [PWM_W-1:0]      pwm_cnt_ff,  pwm_cnt_in;
   logic                  running_ff,  running_in;

   logic                  press;
   logic [DEBOUNCE_W-1:0] count_inc;
   logic                  fire;
   logic [LEVEL_W:0]      level_plus;
   logic [PWM_W-1:0]      duty;
   logic                  pwm_bit;

   always_comb begin
      press = in_speed_ff || in_enable_ff;

      // Saturate the debounce count at its top value.
      count_inc = (count_ff == {DEBOUNCE_W{1'b1}}) ? count_ff
                                                   : count_ff + DEBOUNCE_W'(1);
      fire = !press && active_ff && (count_inc >= debounce_ticks_ff);

      pending_in = pending_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      if (press) begin
         // Speed wins when both buttons land in the same tick.
         pending_in = in_speed_ff ? ACT_SPEED : ACT_ENABLE;
         count_in   = '0;
         active_in  = 1'b1;
      end else if (active_ff) begin
         count_in = count_inc;
         if (fire) begin
            pending_in = ACT_NONE;
            active_in  = 1'b0;
         end
      end

      // Apply the pending action once the debounce window expires.
      level_in   = level_ff;
      enabled_in = enabled_ff;
      level_plus = {1'b0, level_ff} + (LEVEL_W+1)'(1);
      if (fire) begin
         unique case (pending_ff)
            ACT_SPEED: begin
               if (!enabled_ff && (level_ff != LEVEL_OFF)) begin
                  enabled_in = 1'b1;
               end else begin
                  level_in   = (level_plus < (LEVEL_W+1)'(NUM_LEVELS))
                               ? level_plus[LEVEL_W-1:0] : LEVEL_OFF;
                  enabled_in = (level_in != LEVEL_OFF);
               end
            end
            ACT_ENABLE: enabled_in = !enabled_ff;
            default: ;
         endcase
      end

      running_in = running_ff || fire;

      unique case (level_in)
         LEVEL_LOW:  duty = duty_low_ff;
         LEVEL_MID:  duty = duty_mid_ff;
         LEVEL_FULL: duty = duty_full_ff;
         default:    duty = '0;
      endcase
      if (!enabled_in) begin
         duty = '0;
      end

      // Drive from the current count, then advance with wrap at pwm_top.
      pwm_bit    = running_in && (pwm_cnt_ff < duty);
      pwm_cnt_in = pwm_cnt_ff;
      if (running_in) begin
         pwm_cnt_in = (pwm_cnt_ff >= pwm_top_ff) ? '0 : pwm_cnt_ff + PWM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= LEVEL_OFF;
         enabled_ff <= 1'b0;
         pending_ff <= ACT_NONE;
         count_ff   <= '0;
         active_ff  <= 1'b0;
         pwm_cnt_ff <= '0;
         running_ff <= 1'b0;
      end else if (advance) begin
         level_ff   <= level_in;
         enabled_ff <= enabled_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         active_ff  <= active_in;
         pwm_cnt_ff <= pwm_cnt_in;
         running_ff <= running_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic               pwm_out_ff;
   logic               led_low_ff;
   logic               led_mid_ff;
   logic               led_full_ff;
   logic               fan_on_ff;
   logic [LEVEL_W-1:0] level_now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pwm_out_ff   <= pwm_bit;
         led_low_ff   <= enabled_in && (level_in == LEVEL_LOW);
         led_mid_ff   <= enabled_in && (level_in == LEVEL_MID);
         led_full_ff  <= enabled_in && (level_in == LEVEL_FULL);
         fan_on_ff    <= enabled_in;
         level_now_ff <= level_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pwm_out   = pwm_out_ff;
   assign rsp_led_low   = led_low_ff;
   assign rsp_led_mid   = led_mid_ff;
   assign rsp_led_full  = led_full_ff;
   assign rsp_fan_on    = fan_on_ff;
   assign rsp_level_now = level_now_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // At most one speed LED lights, and only with the fan enabled.
   a_led_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_led_low, rsp_led_mid, rsp_led_full}))
      else $error("more than one speed LED lit");

   a_led_needs_fan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_led_low || rsp_led_mid || rsp_led_full)) |-> rsp_fan_on)
      else $error("speed LED lit with fan disabled");

   // No action may wait outside a debounce window.
   a_pending_idle: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (pending_ff == ACT_NONE))
      else $error("pending action without active debounce");

   // The PWM counter holds at zero until the first applied action.
   a_pwm_idle: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (pwm_cnt_ff == '0))
      else $error("PWM counter moved while idle");

   // A stalled result beat must not be overwritten.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_level_now)
                                     && $stable(rsp_pwm_out)))
      else $error("stalled result changed");

endmodule
